// ===== rtl/tdc_pkg.sv =====
// ----------------------------------------------------------------------------
// tdc_pkg: shared types and constants of the telegram deframer/classifier
// Telegram record passed from the deframing front to the result back end,
// answer class codes and the object/error lookup functions.
// ----------------------------------------------------------------------------
package tdc_pkg;

    // Framing constants
    localparam int unsigned LEN_BASE      = 6;    // added to the length nibble
    localparam int unsigned PAYLOAD_COUNT = 6;    // bytes 3..8 are kept
    localparam int unsigned PAYLOAD_FIRST = 3;    // offset of the first kept byte
    localparam int unsigned OBJECT_POS    = 2;    // offset of the object byte
    localparam int unsigned QUEUE_DEPTH_DEF = 2;  // default decoupling queue depth

    // Object codes with a class of their own
    localparam logic [7:0] OBJ_ACTUAL = 8'd71;
    localparam logic [7:0] OBJ_COMM   = 8'd77;
    localparam logic [7:0] OBJ_DEVERR = 8'd255;

    // Answer classes
    typedef enum logic [2:0] {
        CLS_TEXT      = 3'd0,
        CLS_NOMINAL   = 3'd1,
        CLS_WORD      = 3'd2,
        CLS_ACTUAL    = 3'd3,
        CLS_UNHANDLED = 3'd4,
        CLS_COMM_ERR  = 3'd5,
        CLS_DEV_ERR   = 3'd6,
        CLS_UNKNOWN   = 3'd7
    } answer_class_t;

    // One completed telegram
    typedef struct packed {
        logic [7:0]                          object_code;
        logic [4:0]                          length;
        logic [PAYLOAD_COUNT-1:0][7:0]       payload;   // payload[0] is byte 3
    } telegram_t;

    // Object dispatch table
    function automatic answer_class_t class_of(input logic [7:0] obj);
        answer_class_t cls;
        priority if (obj == 8'd0 || obj == 8'd1 || (obj >= 8'd6 && obj <= 8'd13))
            cls = CLS_TEXT;
        else if (obj >= 8'd2 && obj <= 8'd4)
            cls = CLS_NOMINAL;
        else if (obj == 8'd19 || obj == 8'd50 || obj == 8'd51 || obj == 8'd52 ||
                 obj == 8'd70 || obj == 8'd72)
            cls = CLS_WORD;
        else if (obj == OBJ_ACTUAL)
            cls = CLS_ACTUAL;
        else if ((obj >= 8'd22 && obj <= 8'd31) || obj == 8'd37 || obj == 8'd38 ||
                 obj == 8'd54 || (obj >= 8'd190 && obj <= 8'd194))
            cls = CLS_UNHANDLED;
        else if (obj == OBJ_COMM)
            cls = CLS_COMM_ERR;
        else if (obj == OBJ_DEVERR)
            cls = CLS_DEV_ERR;
        else
            cls = CLS_UNKNOWN;
        return cls;
    endfunction

    // Listed device error codes
    function automatic logic error_known(input logic [7:0] code);
        logic known;
        known = (code >= 8'h01 && code <= 8'h0A) ||
                code == 8'h0C || code == 8'h0F ||
                (code >= 8'h10 && code <= 8'h14) ||
                (code >= 8'h20 && code <= 8'h22) ||
                (code >= 8'h30 && code <= 8'h33) ||
                code == 8'h36 || code == 8'h38;
        return known;
    endfunction

endpackage

// ===== rtl/telegram_deframer_classifier.sv =====
// ----------------------------------------------------------------------------
// telegram_deframer_classifier: answer telegram deframer and classifier
// Cuts a received byte stream into telegrams and reports each one decoded.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/rx_byte moves one received byte per beat.
//   A telegram's length is the low nibble of its first byte plus 6 (6..21).
//   Output channel out_valid/out_ready moves one result per completed
//   telegram: object byte, answer class, words from bytes 3..8, raw 32-bit
//   word, device error code and whether it is a listed one, and the length.
//   Bytes missing from a short telegram read as zero; checksum is not checked.
// Timing:
//   One byte is taken every cycle while the queue has room. The result of a
//   telegram is pushed into the queue when its last byte is accepted and
//   then loaded into the output register.
// Reset: the byte counter and the queue are emptied; the next byte starts
//   a new telegram. No output is valid after reset.
// Stall: a stalled receiver holds the output register; telegrams pile up in
//   the queue (QUEUE_DEPTH records), and only when it is full is in_ready
//   dropped.
// ----------------------------------------------------------------------------
module telegram_deframer_classifier #(
    parameter int unsigned QUEUE_DEPTH = tdc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  object_code,
    output logic [2:0]  answer_class,
    output logic [15:0] word_a,
    output logic [15:0] word_b,
    output logic [15:0] word_c,
    output logic [31:0] nominal_raw,
    output logic [7:0]  device_error_code,
    output logic        error_code_known,
    output logic [4:0]  telegram_length
);

    logic               push_valid, push_ready;
    logic               pop_valid, pop_ready;
    tdc_pkg::telegram_t push_data, pop_data;

    // Deframer
    tdc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decoupling queue
    tdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Classifier and output register
    tdc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .pop_valid         (pop_valid),
        .pop_ready         (pop_ready),
        .pop_data          (pop_data),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .object_code       (object_code),
        .answer_class      (answer_class),
        .word_a            (word_a),
        .word_b            (word_b),
        .word_c            (word_c),
        .nominal_raw       (nominal_raw),
        .device_error_code (device_error_code),
        .error_code_known  (error_code_known),
        .telegram_length   (telegram_length)
    );

endmodule

// ===== rtl/tdc_front.sv =====
// ----------------------------------------------------------------------------
// tdc_front: byte deframer
// Counts bytes of the answer stream, keeps the object byte and bytes 3..8,
// and pushes one telegram record when the last byte of a frame arrives.
// ----------------------------------------------------------------------------
module tdc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    output logic                push_valid,
    input  logic                push_ready,
    output tdc_pkg::telegram_t  push_data
);

    localparam int unsigned NB = tdc_pkg::PAYLOAD_COUNT;

    logic [4:0]         pos_reg, pos_next;
    logic [4:0]         exp_len_reg, exp_len_next;
    logic [7:0]         obj_reg, obj_next;
    logic [NB-1:0][7:0] payload_reg, payload_next;
    logic [4:0]         pos_inc;
    logic               accept;
    logic               done;

    // Stall bytes only while the queue cannot take a record
    assign in_ready = push_ready;
    assign accept   = in_valid & in_ready;
    assign pos_inc  = pos_reg + 5'd1;

    // Next frame state for an accepted byte
    always_comb
    begin
        pos_next     = pos_reg;
        exp_len_next = exp_len_reg;
        obj_next     = obj_reg;
        payload_next = payload_reg;
        done         = 1'b0;
        if (pos_reg == 5'd0)
        begin
            exp_len_next = 5'(rx_byte[3:0]) + 5'(tdc_pkg::LEN_BASE);
            payload_next = '0;
            pos_next     = 5'd1;
        end
        else
        begin
            if (pos_reg == 5'(tdc_pkg::OBJECT_POS))
                obj_next = rx_byte;
            for (int i = 0; i < NB; i++)
            begin
                if (pos_reg == 5'(tdc_pkg::PAYLOAD_FIRST + i))
                    payload_next[i] = rx_byte;
            end
            if (pos_inc < exp_len_reg)
                pos_next = pos_inc;
            else
            begin
                pos_next = 5'd0;
                done     = 1'b1;
            end
        end
    end

    // Record of the frame that the current byte completes
    assign push_valid            = accept & done;
    assign push_data.object_code = obj_next;
    assign push_data.length      = exp_len_reg;
    assign push_data.payload     = payload_next;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 5'd0;
            exp_len_reg <= 5'd0;
        end
        else if (accept)
        begin
            pos_reg     <= pos_next;
            exp_len_reg <= exp_len_next;
        end
    end

    // Frame contents
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            obj_reg     <= obj_next;
            payload_reg <= payload_next;
        end
    end

endmodule

// ===== rtl/tdc_queue.sv =====
// ----------------------------------------------------------------------------
// tdc_queue: short telegram queue
// Register-based FIFO that decouples the deframer from the result stage.
// ----------------------------------------------------------------------------
module tdc_queue #(
    parameter int unsigned DEPTH = tdc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  tdc_pkg::telegram_t  push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output tdc_pkg::telegram_t  pop_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    tdc_pkg::telegram_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/tdc_back.sv =====
// ----------------------------------------------------------------------------
// tdc_back: result stage
// Classifies a queued telegram, forms the word fields and holds the result
// in an output register until the receiver takes the beat.
// ----------------------------------------------------------------------------
module tdc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  tdc_pkg::telegram_t  pop_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          object_code,
    output logic [2:0]          answer_class,
    output logic [15:0]         word_a,
    output logic [15:0]         word_b,
    output logic [15:0]         word_c,
    output logic [31:0]         nominal_raw,
    output logic [7:0]          device_error_code,
    output logic                error_code_known,
    output logic [4:0]          telegram_length
);

    logic        valid_reg;
    logic [7:0]  obj_reg;
    logic [2:0]  cls_reg;
    logic [15:0] wa_reg, wb_reg, wc_reg;
    logic [7:0]  ec_reg;
    logic        ek_reg;
    logic [4:0]  len_reg;
    logic        load;
    logic        is_dev_err;

    assign pop_ready  = !valid_reg || out_ready;
    assign load       = pop_valid & pop_ready;
    assign is_dev_err = (pop_data.object_code == tdc_pkg::OBJ_DEVERR);

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop_ready)
            valid_reg <= pop_valid;
    end

    // Result fields
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            obj_reg <= pop_data.object_code;
            cls_reg <= tdc_pkg::class_of(pop_data.object_code);
            wa_reg  <= {pop_data.payload[0], pop_data.payload[1]};
            wb_reg  <= {pop_data.payload[2], pop_data.payload[3]};
            wc_reg  <= {pop_data.payload[4], pop_data.payload[5]};
            ec_reg  <= is_dev_err ? pop_data.payload[0] : 8'd0;
            ek_reg  <= is_dev_err & tdc_pkg::error_known(pop_data.payload[0]);
            len_reg <= pop_data.length;
        end
    end

    assign out_valid         = valid_reg;
    assign object_code       = obj_reg;
    assign answer_class      = cls_reg;
    assign word_a            = wa_reg;
    assign word_b            = wb_reg;
    assign word_c            = wc_reg;
    assign nominal_raw       = {wa_reg, wb_reg};
    assign device_error_code = ec_reg;
    assign error_code_known  = ek_reg;
    assign telegram_length   = len_reg;

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench of the telegram deframer/classifier
// Feeds the byte stream through valid/ready with random idling on both sides.
// A short directed table opens the run; its first three telegrams end in rows
// with hand-decoded answers. Random telegrams with some stray bytes follow.
// Every byte that is taken also runs through a local deframer that queues the
// expected answer of each telegram it completes. Each answer from the block
// is compared field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_BYTES  = 232;

    // Decoded answer of one telegram, as seen on the output ports
    typedef struct packed {
        logic [7:0]             obj;
        tdc_pkg::answer_class_t cls;
        logic [15:0]            wa;
        logic [15:0]            wb;
        logic [15:0]            wc;
        logic [31:0]            raw;
        logic [7:0]             err;
        logic                   known;
        logic [4:0]             len;
    } decoded_t;

    // One row of the directed table
    typedef struct packed {
        logic [7:0] b;
        bit         literal;
        decoded_t   ans;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  object_code;
    logic [2:0]  answer_class;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [31:0] nominal_raw;
    logic [7:0]  device_error_code;
    logic        error_code_known;
    logic [4:0]  telegram_length;

    telegram_deframer_classifier u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .object_code       (object_code),
        .answer_class      (answer_class),
        .word_a            (word_a),
        .word_b            (word_b),
        .word_c            (word_c),
        .nominal_raw       (nominal_raw),
        .device_error_code (device_error_code),
        .error_code_known  (error_code_known),
        .telegram_length   (telegram_length)
    );

    // Deframer state of the predictor
    logic [4:0] frame_pos = 5'd0;
    logic [4:0] frame_len = 5'd0;
    logic [7:0] frame_obj = 8'd0;
    logic [7:0] frame_body [6] = '{default: 8'd0};

    decoded_t pending_answers [$];
    stim_row_t directed_rows [$];

    bit saw_error = 1'b0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int bytes_sent = 0;
    int cycle_count = 0;

    // Objects worth hitting: every class plus the edges of the table ranges
    logic [7:0] object_picks [24] = '{
        8'd0, 8'd1, 8'd5, 8'd6, 8'd13, 8'd14, 8'd2, 8'd4, 8'd19, 8'd50, 8'd52, 8'd53,
        8'd70, 8'd72, 8'd71, 8'd22, 8'd31, 8'd37, 8'd38, 8'd54, 8'd190, 8'd194,
        8'd77, 8'd255
    };

    // Device error codes: listed ones and their neighbors
    logic [7:0] code_picks [20] = '{
        8'h00, 8'h01, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0F, 8'h10, 8'h14, 8'h15,
        8'h20, 8'h22, 8'h23, 8'h30, 8'h33, 8'h34, 8'h36, 8'h37, 8'h38, 8'h39
    };

    // Object dispatch
    function automatic tdc_pkg::answer_class_t object_class(input logic [7:0] obj);
        tdc_pkg::answer_class_t cls;
        case (obj) inside
            8'd0, 8'd1, [8'd6:8'd13]:
                cls = tdc_pkg::CLS_TEXT;
            [8'd2:8'd4]:
                cls = tdc_pkg::CLS_NOMINAL;
            8'd19, [8'd50:8'd52], 8'd70, 8'd72:
                cls = tdc_pkg::CLS_WORD;
            tdc_pkg::OBJ_ACTUAL:
                cls = tdc_pkg::CLS_ACTUAL;
            [8'd22:8'd31], 8'd37, 8'd38, 8'd54, [8'd190:8'd194]:
                cls = tdc_pkg::CLS_UNHANDLED;
            tdc_pkg::OBJ_COMM:
                cls = tdc_pkg::CLS_COMM_ERR;
            tdc_pkg::OBJ_DEVERR:
                cls = tdc_pkg::CLS_DEV_ERR;
            default:
                cls = tdc_pkg::CLS_UNKNOWN;
        endcase
        return cls;
    endfunction

    // Listed device error codes
    function automatic logic code_listed(input logic [7:0] code);
        logic hit;
        case (code) inside
            [8'h01:8'h0A], 8'h0C, 8'h0F, [8'h10:8'h14], [8'h20:8'h22],
            [8'h30:8'h33], 8'h36, 8'h38: hit = 1'b1;
            default:                     hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic decoded_t answer_of(input logic [7:0] obj,
                                           input tdc_pkg::answer_class_t cls,
                                           input logic [15:0] wa, input logic [15:0] wb,
                                           input logic [15:0] wc, input logic [31:0] raw,
                                           input logic [7:0] err, input logic known,
                                           input logic [4:0] len);
        decoded_t a;
        a.obj = obj;
        a.cls = cls;
        a.wa = wa;
        a.wb = wb;
        a.wc = wc;
        a.raw = raw;
        a.err = err;
        a.known = known;
        a.len = len;
        return a;
    endfunction

    function automatic stim_row_t row(input logic [7:0] b, input bit literal = 1'b0,
                                      input decoded_t ans = '0);
        stim_row_t r;
        r.b = b;
        r.literal = literal;
        r.ans = ans;
        return r;
    endfunction

    // Predictor: deframe one byte, give the answer when a telegram completes
    task automatic deframe_byte(input logic [7:0] b, output bit done, output decoded_t ans);
        logic [4:0] next_pos;
        int k;
        done = 1'b0;
        ans = '0;
        if (frame_pos == 5'd0)
        begin
            frame_len = b[3:0] + 5'd6;
            for (k = 0; k < 6; k++)
                frame_body[k] = 8'd0;
            frame_pos = 5'd1;
        end
        else
        begin
            if (frame_pos == 5'(tdc_pkg::OBJECT_POS))
                frame_obj = b;
            if (frame_pos >= 5'd3 && frame_pos <= 5'd8)
                frame_body[3'(frame_pos - 5'd3)] = b;
            next_pos = frame_pos + 5'd1;
            if (next_pos < frame_len)
                frame_pos = next_pos;
            else
            begin
                // Missing bytes of a short telegram are still zero here
                ans.obj = frame_obj;
                ans.cls = object_class(frame_obj);
                ans.wa = {frame_body[0], frame_body[1]};
                ans.wb = {frame_body[2], frame_body[3]};
                ans.wc = {frame_body[4], frame_body[5]};
                ans.raw = {ans.wa, ans.wb};
                ans.err = (frame_obj == tdc_pkg::OBJ_DEVERR) ? frame_body[0] : 8'd0;
                ans.known = (frame_obj == tdc_pkg::OBJ_DEVERR) ?
                            code_listed(frame_body[0]) : 1'b0;
                ans.len = frame_len;
                done = 1'b1;
                frame_pos = 5'd0;
            end
        end
    endtask

    // Drive one beat; called at a rising edge, returns at the edge that takes it
    task automatic send_byte(input logic [7:0] b, input bit literal = 1'b0,
                             input decoded_t given = '0);
        bit done;
        decoded_t ans;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        deframe_byte(b, done, ans);
        if (literal)
            pending_answers.push_back(given);
        else if (done)
            pending_answers.push_back(ans);
    endtask

    // One random telegram, now and then preceded by stray bytes
    task automatic send_telegram();
        logic [7:0] hdr;
        logic [7:0] obj;
        logic [7:0] b;
        int len;
        int k;
        if ($urandom_range(0, 99) < 8)
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom_range(0, 255)));
        hdr[7:4] = 4'($urandom_range(0, 15));
        // Mostly short telegrams, full length range now and then
        if ($urandom_range(0, 99) < 70)
            hdr[3:0] = 4'($urandom_range(0, 3));
        else
            hdr[3:0] = 4'($urandom_range(0, 15));
        len = int'(hdr[3:0]) + 6;
        if ($urandom_range(0, 99) < 35)
            obj = 8'($urandom_range(0, 255));
        else
            obj = object_picks[$urandom_range(0, 23)];
        send_byte(hdr);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(obj);
        for (k = 3; k < len; k++)
        begin
            b = 8'($urandom_range(0, 255));
            if (k == 3 && obj == tdc_pkg::OBJ_DEVERR && $urandom_range(0, 1) == 1)
                b = code_picks[$urandom_range(0, 19)];
            send_byte(b);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            saw_error = 1'b1;
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: random stalls, compare each answer beat with the oldest expected
    always @(posedge clk)
    begin
        decoded_t want;
        if (out_valid && out_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                saw_error = 1'b1;
                $display("%0t: answer expected none, got object %h class %0d length %0d",
                         $time, object_code, answer_class, telegram_length);
            end
            else
            begin
                want = pending_answers.pop_front();
                check_field("object_code", want.obj, object_code);
                check_field("answer_class", want.cls, answer_class);
                check_field("word_a", want.wa, word_a);
                check_field("word_b", want.wb, word_b);
                check_field("word_c", want.wc, word_c);
                check_field("nominal_raw", want.raw, nominal_raw);
                check_field("device_error_code", want.err, device_error_code);
                check_field("error_code_known", want.known, error_code_known);
                check_field("telegram_length", want.len, telegram_length);
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Stimulus
    initial
    begin
        int phase;
        int target;
        int phase_idle [4];
        int phase_stall [4];
        phase_idle = '{0, 55, 0, 29};
        phase_stall = '{0, 0, 55, 29};

        // Known device error, shortest telegram, first frame after reset
        directed_rows.push_back(row(8'h00));
        directed_rows.push_back(row(8'hFF));
        directed_rows.push_back(row(tdc_pkg::OBJ_DEVERR));
        directed_rows.push_back(row(8'h01));
        directed_rows.push_back(row(8'hFF));
        directed_rows.push_back(row(8'h00, 1'b1,
            answer_of(8'hFF, tdc_pkg::CLS_DEV_ERR, 16'h01FF, 16'h0000, 16'h0000,
                      32'h01FF0000, 8'h01, 1'b1, 5'd6)));
        // Unlisted device error; high nibble of the header is ignored
        directed_rows.push_back(row(8'hF0));
        directed_rows.push_back(row(8'h00));
        directed_rows.push_back(row(tdc_pkg::OBJ_DEVERR));
        directed_rows.push_back(row(8'h0B));
        directed_rows.push_back(row(8'h00));
        directed_rows.push_back(row(8'hFF, 1'b1,
            answer_of(8'hFF, tdc_pkg::CLS_DEV_ERR, 16'h0B00, 16'hFF00, 16'h0000,
                      32'h0B00FF00, 8'h0B, 1'b0, 5'd6)));
        // Actual values with every payload byte at its maximum
        directed_rows.push_back(row(8'h03));
        directed_rows.push_back(row(8'hA5));
        directed_rows.push_back(row(tdc_pkg::OBJ_ACTUAL));
        repeat (5)
            directed_rows.push_back(row(8'hFF));
        directed_rows.push_back(row(8'hFF, 1'b1,
            answer_of(tdc_pkg::OBJ_ACTUAL, tdc_pkg::CLS_ACTUAL, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 32'hFFFFFFFF, 8'h00, 1'b0, 5'd9)));
        // Comm error, short telegram
        directed_rows.push_back(row(8'h50));
        directed_rows.push_back(row(8'h12));
        directed_rows.push_back(row(tdc_pkg::OBJ_COMM));
        directed_rows.push_back(row(8'h34));
        directed_rows.push_back(row(8'h56));
        directed_rows.push_back(row(8'h78));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].b, directed_rows[i].literal, directed_rows[i].ans);

        // Random telegrams under each idling mix
        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = phase_idle[phase];
            recv_stall_pct = phase_stall[phase];
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target)
                send_telegram();
        end
        in_valid <= 1'b0;

        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (!saw_error && pending_answers.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tdc_pkg.sv
rtl/tdc_front.sv
rtl/tdc_queue.sv
rtl/tdc_back.sv
rtl/telegram_deframer_classifier.sv
sim/tb.sv
